// ===== sv/pow_difficulty_retarget_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the retarget block
// Short forms for clocked implications under the active-low reset.
// ----------------------------------------------------------------------------
`ifndef POW_DIFFICULTY_RETARGET_TOP_MACROS_SVH
`define POW_DIFFICULTY_RETARGET_TOP_MACROS_SVH

// Same-cycle implication.
`define PDR_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdr assertion failed");

// Next-cycle implication.
`define PDR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdr assertion failed");

`endif

// ===== sv/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared constants and types of the difficulty retarget block.
// ----------------------------------------------------------------------------
`default_nettype none

package pdr_pkg;

    localparam int PDR_TARGET_WIDTH = 256;
    localparam int TS_W             = 20;
    localparam int SPAN_W           = 22;
    localparam int BITS_W           = 32;
    localparam int HEIGHT_W         = 31;
    localparam int TIME_W           = 32;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;
    localparam int CELL_BITS        = 8;

    localparam logic [TS_W-1:0]   TS_RESET     = 20'd60;
    localparam logic              DAMPED_RESET = 1'b1;
    localparam logic [BITS_W-1:0] LIMIT_RESET  = 32'h1E0F_FFFF;

    localparam logic [31:0] HEIGHT_TIER1 = 32'd5000;
    localparam logic [31:0] HEIGHT_TIER2 = 32'd10000;

    typedef enum logic [1:0] {
        REG_TIMESPAN = 2'd0,
        REG_DAMPED   = 2'd1,
        REG_LIMIT    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [TS_W-1:0]   timespan;
        logic              damped;
        logic [BITS_W-1:0] limit;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/pdr_decode.sv =====
// ----------------------------------------------------------------------------
// pdr_decode
// Expands a compact target into a full-width target value.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_decode
    import pdr_pkg::*;
#(
    parameter int W = PDR_TARGET_WIDTH
)
(
    input  wire logic [BITS_W-1:0] bits,
    output logic      [W-1:0]      value
);

    logic [7:0]  size;
    logic [22:0] mant;
    logic [4:0]  sh_r;
    logic [10:0] sh_l;

    assign size = bits[31:24];
    assign mant = bits[22:0];

    always_comb
    begin
        sh_r = {2'd3 - size[1:0], 3'b000};
        sh_l = {size - 8'd3, 3'b000};
        if (size <= 8'd3)
        begin
            value = W'(mant >> sh_r);
        end
        else
        begin
            value = W'(mant) << sh_l;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pdr_front.sv =====
// ----------------------------------------------------------------------------
// pdr_front
// Works out the clamped timespan and decodes the request's target.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_front
    import pdr_pkg::*;
#(
    parameter int W = PDR_TARGET_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire cfg_t                cfg,
    input  wire logic                valid_i,
    input  wire logic [HEIGHT_W-1:0] height_i,
    input  wire logic [BITS_W-1:0]   bits_i,
    input  wire logic [TIME_W-1:0]   t_last_i,
    input  wire logic [TIME_W-1:0]   t_first_i,
    output logic                     valid_o,
    output logic      [SPAN_W-1:0]   span_o,
    output logic      [W-1:0]        dec_o
);

    logic signed [35:0] t_s;
    logic signed [35:0] span_s;
    logic signed [35:0] diff_s;
    logic signed [35:0] q_s;
    logic signed [35:0] sd_s;
    logic signed [35:0] lo_s;
    logic signed [35:0] hi_s;
    logic signed [35:0] cl_s;
    logic [31:0]        height_next;
    logic [W-1:0]       dec;

    logic              valid_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [SPAN_W-1:0] span_next;
    logic [W-1:0]      dec_reg;

    pdr_decode #(.W(W)) u_decode
    (
        .bits  (bits_i),
        .value (dec)
    );

    always_comb
    begin
        t_s         = $signed({16'b0, cfg.timespan});
        span_s      = $signed({4'b0, t_last_i}) - $signed({4'b0, t_first_i});
        diff_s      = span_s - t_s;
        height_next = {1'b0, height_i} + 32'd1;
        q_s = diff_s[35] ? ((diff_s + 36'sd7) >>> 3) : (diff_s >>> 3);
        if (cfg.damped)
        begin
            sd_s = t_s + q_s;
            lo_s = t_s - (t_s >>> 2);
            hi_s = t_s + (t_s >>> 1);
        end
        else
        begin
            sd_s = span_s;
            priority if (height_next > HEIGHT_TIER2)
            begin
                lo_s = t_s >>> 2;
            end
            else if (height_next > HEIGHT_TIER1)
            begin
                lo_s = t_s >>> 3;
            end
            else
            begin
                lo_s = t_s >>> 4;
            end
            hi_s = t_s <<< 2;
        end
        priority if (sd_s < lo_s)
        begin
            cl_s = lo_s;
        end
        else if (sd_s > hi_s)
        begin
            cl_s = hi_s;
        end
        else
        begin
            cl_s = sd_s;
        end
        span_next = cl_s[SPAN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            span_reg <= span_next;
            dec_reg  <= dec;
        end
    end

    assign valid_o = valid_reg;
    assign span_o  = span_reg;
    assign dec_o   = dec_reg;

endmodule

`default_nettype wire

// ===== sv/pdr_mul.sv =====
// ----------------------------------------------------------------------------
// pdr_mul
// Multiplies the target by the timespan, limb products then one wide add.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_mul
    import pdr_pkg::*;
#(
    parameter int W = PDR_TARGET_WIDTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              valid_i,
    input  wire logic [SPAN_W-1:0] span_i,
    input  wire logic [W-1:0]      dec_i,
    output logic                   valid_o,
    output logic      [W-1:0]      prod_o
);

    localparam int LIMBS = (W + 31) / 32;
    localparam int PW    = LIMBS * 32;
    localparam int PRW   = SPAN_W + 32;

    logic [PW-1:0]  dec_pad;
    logic [PRW-1:0] part_reg [LIMBS];
    logic           part_valid_reg;
    logic [PW-1:0]  ev;
    logic [PW-1:0]  od;
    logic           prod_valid_reg;
    logic [W-1:0]   prod_reg;
    logic [W-1:0]   prod_next;

    assign dec_pad = PW'(dec_i);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LIMBS; i++)
            begin
                part_reg[i] <= PRW'(dec_pad[32*i +: 32]) * PRW'(span_i);
            end
        end
    end

    always_comb
    begin
        ev = '0;
        od = '0;
        for (int i = 0; i < LIMBS; i++)
        begin
            if (i[0] == 1'b0)
            begin
                ev = ev | (PW'(part_reg[i]) << (32 * i));
            end
            else
            begin
                od = od | (PW'(part_reg[i]) << (32 * i));
            end
        end
        prod_next = W'(ev + od);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            part_valid_reg <= valid_i;
            prod_valid_reg <= part_valid_reg;
        end
    end

    assign valid_o = prod_valid_reg;
    assign prod_o  = prod_reg;

endmodule

`default_nettype wire

// ===== sv/pdr_div_cell.sv =====
// ----------------------------------------------------------------------------
// pdr_div_cell
// Divider chain cell: eight restoring quotient bits per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_div_cell
    import pdr_pkg::*;
#(
    parameter int DW = PDR_TARGET_WIDTH
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic [TS_W-1:0] divisor,
    input  wire logic            valid_i,
    input  wire logic [DW-1:0]   acc_i,
    input  wire logic [TS_W-1:0] rem_i,
    output logic                 valid_o,
    output logic      [DW-1:0]   acc_o,
    output logic      [TS_W-1:0] rem_o
);

    logic [DW-1:0]   acc_next;
    logic [TS_W-1:0] rem_next;
    logic [TS_W:0]   trial;
    logic            valid_reg;
    logic [DW-1:0]   acc_reg;
    logic [TS_W-1:0] rem_reg;

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb
    begin
        acc_next = acc_i;
        rem_next = rem_i;
        trial    = '0;
        for (int k = 0; k < CELL_BITS; k++)
        begin
            trial    = {rem_next, acc_next[DW-1]};
            acc_next = {acc_next[DW-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial       = trial - {1'b0, divisor};
                acc_next[0] = 1'b1;
            end
            rem_next = trial[TS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign valid_o = valid_reg;
    assign acc_o   = acc_reg;
    assign rem_o   = rem_reg;

endmodule

`default_nettype wire

// ===== sv/pdr_back.sv =====
// ----------------------------------------------------------------------------
// pdr_back
// Caps the new target at the limit and encodes it in compact form.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_back
    import pdr_pkg::*;
#(
    parameter int W  = PDR_TARGET_WIDTH,
    parameter int DW = PDR_TARGET_WIDTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic [W-1:0]      limit_i,
    input  wire logic              valid_i,
    input  wire logic [W-1:0]      quo_i,
    output logic                   valid_o,
    output logic      [BITS_W-1:0] bits_o
);

    localparam int NB = DW / CELL_BITS;
    localparam int NW = $clog2(NB + 2);

    logic [W-1:0]      lim_reg;
    logic              cap_valid_reg;
    logic [W-1:0]      cap_reg;
    logic [DW-1:0]     cap_pad;
    logic [NW-1:0]     n_next;
    logic              cnt_valid_reg;
    logic [DW-1:0]     cnt_val_reg;
    logic [NW-1:0]     cnt_n_reg;
    logic [DW+23:0]    wide;
    logic [23:0]       c;
    logic [NW-1:0]     e;
    logic [23:0]       mant;
    logic              out_valid_reg;
    logic [BITS_W-1:0] out_bits_reg;
    logic [BITS_W-1:0] out_bits_next;

    always_ff @(posedge clk)
    begin
        lim_reg <= limit_i;
        if (adv)
        begin
            cap_reg      <= (quo_i > lim_reg) ? lim_reg : quo_i;
            cnt_val_reg  <= cap_pad;
            cnt_n_reg    <= n_next;
            out_bits_reg <= out_bits_next;
        end
    end

    assign cap_pad = DW'(cap_reg);

    always_comb
    begin
        n_next = '0;
        for (int i = 0; i < NB; i++)
        begin
            if (cap_pad[CELL_BITS*i +: CELL_BITS] != '0)
            begin
                n_next = NW'(i + 1);
            end
        end
    end

    always_comb
    begin
        wide = {cnt_val_reg, 24'b0};
        c    = wide[{cnt_n_reg, 3'b000} +: 24];
        if (c[23])
        begin
            mant = {8'b0, c[23:8]};
            e    = cnt_n_reg + NW'(1);
        end
        else
        begin
            mant = c;
            e    = cnt_n_reg;
        end
        out_bits_next = {8'(e), mant};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_valid_reg <= 1'b0;
            cnt_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cap_valid_reg <= valid_i;
            cnt_valid_reg <= cap_valid_reg;
            out_valid_reg <= cnt_valid_reg;
        end
    end

    assign valid_o = out_valid_reg;
    assign bits_o  = out_bits_reg;

endmodule

`default_nettype wire

// ===== sv/pow_difficulty_retarget_top.sv =====
// ----------------------------------------------------------------------------
// pow_difficulty_retarget_top
// Pipeline: front stage, multiplier, a divider chain of eight-bit cells
// and the capping and encoding stages at the back.
// Throughput: one request per cycle; the whole pipeline holds while the
// output is stalled. Reset empties the pipeline and loads the register
// defaults: timespan 60, damped mode on, limit 0x1E0FFFFF.
// ----------------------------------------------------------------------------
`default_nettype none

module pow_difficulty_retarget_top
    import pdr_pkg::*;
#(
    parameter int TARGET_WIDTH = PDR_TARGET_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire logic [HEIGHT_W-1:0] last_height,
    input  wire logic [BITS_W-1:0]   last_bits,
    input  wire logic [TIME_W-1:0]   last_block_time,
    input  wire logic [TIME_W-1:0]   first_block_time,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output logic      [BITS_W-1:0]   next_bits
);

    localparam int NCELLS = (TARGET_WIDTH + CELL_BITS - 1) / CELL_BITS;
    localparam int DW     = NCELLS * CELL_BITS;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t wr_idx;
    logic     wr_en;
    logic     adv;

    logic                    f_valid;
    logic [SPAN_W-1:0]       f_span;
    logic [TARGET_WIDTH-1:0] f_dec;
    logic                    m_valid;
    logic [TARGET_WIDTH-1:0] m_prod;
    logic [TARGET_WIDTH-1:0] lim_dec;

    logic            c_valid [NCELLS+1];
    logic [DW-1:0]   c_acc   [NCELLS+1];
    logic [TS_W-1:0] c_rem   [NCELLS+1];

    assign pready = 1'b1;
    assign wr_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (wr_idx)
            REG_TIMESPAN:
            begin
                prdata = PDATA_W'(cfg_reg.timespan);
                if (wr_en)
                begin
                    cfg_next.timespan = pwdata[TS_W-1:0];
                end
            end
            REG_DAMPED:
            begin
                prdata = PDATA_W'(cfg_reg.damped);
                if (wr_en)
                begin
                    cfg_next.damped = pwdata[0];
                end
            end
            REG_LIMIT:
            begin
                prdata = cfg_reg.limit;
                if (wr_en)
                begin
                    cfg_next.limit = pwdata;
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timespan <= TS_RESET;
            cfg_reg.damped   <= DAMPED_RESET;
            cfg_reg.limit    <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    pdr_front #(.W(TARGET_WIDTH)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg_reg),
        .valid_i   (req_valid),
        .height_i  (last_height),
        .bits_i    (last_bits),
        .t_last_i  (last_block_time),
        .t_first_i (first_block_time),
        .valid_o   (f_valid),
        .span_o    (f_span),
        .dec_o     (f_dec)
    );

    pdr_mul #(.W(TARGET_WIDTH)) u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .valid_i (f_valid),
        .span_i  (f_span),
        .dec_i   (f_dec),
        .valid_o (m_valid),
        .prod_o  (m_prod)
    );

    assign c_valid[0] = m_valid;
    assign c_acc[0]   = DW'(m_prod);
    assign c_rem[0]   = '0;

    for (genvar g = 0; g < NCELLS; g++)
    begin : g_cell
        pdr_div_cell #(.DW(DW)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .divisor (cfg_reg.timespan),
            .valid_i (c_valid[g]),
            .acc_i   (c_acc[g]),
            .rem_i   (c_rem[g]),
            .valid_o (c_valid[g+1]),
            .acc_o   (c_acc[g+1]),
            .rem_o   (c_rem[g+1])
        );
    end

    pdr_decode #(.W(TARGET_WIDTH)) u_lim_decode
    (
        .bits  (cfg_reg.limit),
        .value (lim_dec)
    );

    pdr_back #(.W(TARGET_WIDTH), .DW(DW)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .limit_i (lim_dec),
        .valid_i (c_valid[NCELLS]),
        .quo_i   (c_acc[NCELLS][TARGET_WIDTH-1:0]),
        .valid_o (rsp_valid),
        .bits_o  (next_bits)
    );

endmodule

`default_nettype wire

// ===== sv/pdr_checker.sv =====
// ----------------------------------------------------------------------------
// pdr_checker
// Port-level checks on the result channel and on request backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pow_difficulty_retarget_top_macros.svh"

module pdr_checker
    import pdr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_stall,
    input wire logic              rsp_valid,
    input wire logic              rsp_stall,
    input wire logic [BITS_W-1:0] next_bits
);

    `PDR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
    `PDR_ASSERT_NEXT(a_bits_hold, rsp_valid && rsp_stall, $stable(next_bits))
    `PDR_ASSERT_IMP(a_backpressure, rsp_valid && rsp_stall, req_stall)
    `PDR_ASSERT_IMP(a_flow, !rsp_stall, !req_stall)

endmodule

bind pow_difficulty_retarget_top pdr_checker u_pdr_checker (.*);

`default_nettype wire
